FILE: sv/tas_pkg.sv
// Shared types and constants for the timed action scheduler.
`default_nettype none

package tas_pkg;

    // Request opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Action codes: NONE marks a free slot, POWER_ON..FAN_OFF are the known commands
    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_POWER_ON = 4'd1;
    localparam logic [3:0] ACT_FAN_OFF  = 4'd4;

    // Result kinds
    localparam logic KIND_KNOWN   = 1'b0;
    localparam logic KIND_UNKNOWN = 1'b1;

    // Number of addressable target units
    localparam int unsigned NUM_TARGETS = 8;

    // Results emitted per tick at most, and the counter that tracks them
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FLUSH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the incoming request, restart index and count
        logic idx_inc;    // step to the next slot
        logic add_write;  // store the latched add into the current slot
        logic slot_clear; // free the current slot
        logic fire;       // take the current slot as a result
        logic flush_out;  // send the held result as the final one of the tick
        logic tick_done;  // last tick time takes the latched now
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;  // current slot holds no action
        logic idx_end;    // current slot is the highest one
        logic due;        // current slot deadline lies in the tick window
        logic live;       // current slot holds an action and the result budget is left
        logic pend_valid; // a result is held back waiting for its last flag
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage

`default_nettype wire

FILE: sv/tas_ctrl.sv
// Sequencer for add and tick requests of the timed action scheduler.
`default_nettype none

module tas_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           op,
    output logic                in_ready,
    input  wire tas_pkg::sts_t  sts,
    output tas_pkg::cmd_t       cmd
);

    tas_pkg::state_t state_reg;
    tas_pkg::state_t state_next;
    logic            fire_now;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tas_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign fire_now = sts.due && sts.live;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tas_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op == tas_pkg::OP_TICK) ? tas_pkg::ST_SCAN_RD
                                                          : tas_pkg::ST_ADD;
                end
            end
            // walk up to the lowest free slot; drop the add when none is free
            tas_pkg::ST_ADD:
            begin
                if (sts.slot_free)
                begin
                    cmd.add_write = 1'b1;
                    state_next    = tas_pkg::ST_IDLE;
                end
                else if (sts.idx_end)
                begin
                    state_next = tas_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            tas_pkg::ST_SCAN_RD:
            begin
                state_next = tas_pkg::ST_SCAN_EV;
            end
            // a new firing pushes the held one out, so wait for room
            tas_pkg::ST_SCAN_EV:
            begin
                if (!(fire_now && sts.pend_valid && !sts.out_free))
                begin
                    cmd.slot_clear = sts.due;
                    cmd.fire       = fire_now;
                    if (sts.idx_end)
                    begin
                        state_next = tas_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = tas_pkg::ST_SCAN_RD;
                    end
                end
            end
            tas_pkg::ST_FLUSH:
            begin
                if (!(sts.pend_valid && !sts.out_free))
                begin
                    cmd.flush_out = sts.pend_valid;
                    cmd.tick_done = 1'b1;
                    state_next    = tas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tas_pkg::ST_IDLE;
            end
        endcase
    end

    // A held result never survives into idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tas_pkg::ST_IDLE) |-> !sts.pend_valid)
        else $error("held result left over after tick");

    // A firing that would overwrite a full output register is not issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire && sts.pend_valid) |-> sts.out_free)
        else $error("result pushed into busy output register");

endmodule

`default_nettype wire

FILE: sv/tas_dp.sv
// Slot storage, tick window compare and result registers of the scheduler.
`default_nettype none

module tas_dp #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tas_pkg::cmd_t  cmd,
    output tas_pkg::sts_t       sts,
    input  wire logic [31:0]    now_ms,
    input  wire logic [3:0]     action_code,
    input  wire logic [2:0]     target_id,
    input  wire logic [31:0]    delay_ms,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                kind,
    output logic [3:0]          action_out,
    output logic [2:0]          target_out,
    output logic [2:0]          slot_out,
    output logic                last
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Latched request
    logic [31:0]               now_reg;
    logic [3:0]                act_in_reg;
    logic [2:0]                tgt_in_reg;
    logic [31:0]               dl_in_reg;

    logic [IDX_W-1:0]          idx_reg;
    logic [tas_pkg::CNT_W-1:0] cnt_reg;
    logic [31:0]               last_tick_reg;

    // Slot store: actions in flops (reset free), deadline and target in memory
    logic [3:0]                slot_action_reg [NUM_SLOTS];
    logic [31:0]               deadline_mem    [NUM_SLOTS];
    logic [2:0]                target_mem      [NUM_SLOTS];
    logic [31:0]               rd_dl_reg;
    logic [2:0]                rd_tgt_reg;

    // Held result and output register
    logic                      pend_valid_reg;
    logic                      pend_kind_reg;
    logic [3:0]                pend_act_reg;
    logic [2:0]                pend_tgt_reg;
    logic [2:0]                pend_slot_reg;
    logic                      out_valid_reg;
    logic                      kind_reg;
    logic [3:0]                action_reg;
    logic [2:0]                target_reg;
    logic [2:0]                slot_reg;
    logic                      last_reg;

    logic [3:0]                cur_act;
    logic                      in_win;
    logic                      wrapped;
    logic                      known;
    logic                      push;
    logic [31:0]               idx_ext;

    assign cur_act = slot_action_reg[idx_reg];
    assign idx_ext = 32'(idx_reg);

    // Tick window: (last, now], or both ends open around the wrap
    assign in_win  = (rd_dl_reg > last_tick_reg) && (rd_dl_reg <= now_reg);
    assign wrapped = (now_reg < last_tick_reg)
                     && ((rd_dl_reg > last_tick_reg) || (rd_dl_reg < now_reg));

    assign known = (cur_act >= tas_pkg::ACT_POWER_ON) && (cur_act <= tas_pkg::ACT_FAN_OFF)
                   && (32'(rd_tgt_reg) < tas_pkg::NUM_TARGETS);

    assign push = (cmd.fire && pend_valid_reg) || cmd.flush_out;

    // Status to the controller
    always_comb
    begin
        sts.slot_free  = (cur_act == tas_pkg::ACT_NONE);
        sts.idx_end    = (idx_reg == IDX_W'(NUM_SLOTS - 1));
        sts.due        = in_win || wrapped;
        sts.live       = (cur_act != tas_pkg::ACT_NONE)
                         && (32'(cnt_reg) < tas_pkg::MAX_RESULTS);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= now_ms;
            act_in_reg <= action_code;
            tgt_in_reg <= target_id;
            dl_in_reg  <= delay_ms;
        end
    end

    // Index, result count and last tick time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            last_tick_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.fire)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.tick_done)
            begin
                last_tick_reg <= now_reg;
            end
        end
    end

    // Slot actions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_action_reg[i] <= tas_pkg::ACT_NONE;
            end
        end
        else if (cmd.add_write)
        begin
            slot_action_reg[idx_reg] <= act_in_reg;
        end
        else if (cmd.slot_clear)
        begin
            slot_action_reg[idx_reg] <= tas_pkg::ACT_NONE;
        end
    end

    // Deadline and target memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            deadline_mem[idx_reg] <= now_reg + dl_in_reg;
            target_mem[idx_reg]   <= tgt_in_reg;
        end
        rd_dl_reg  <= deadline_mem[idx_reg];
        rd_tgt_reg <= target_mem[idx_reg];
    end

    // Held result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.flush_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            pend_kind_reg <= known ? tas_pkg::KIND_KNOWN : tas_pkg::KIND_UNKNOWN;
            pend_act_reg  <= cur_act;
            pend_tgt_reg  <= rd_tgt_reg;
            pend_slot_reg <= idx_ext[2:0];
        end
        if (push)
        begin
            kind_reg   <= pend_kind_reg;
            action_reg <= pend_act_reg;
            target_reg <= pend_tgt_reg;
            slot_reg   <= pend_slot_reg;
            last_reg   <= cmd.flush_out;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign action_out = action_reg;
    assign target_out = target_reg;
    assign slot_out   = slot_reg;
    assign last       = last_reg;

    // Result budget per tick is never exceeded
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= tas_pkg::MAX_RESULTS)
        else $error("result count over budget");

    // A slot is never filled and freed in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.add_write && cmd.slot_clear))
        else $error("add and clear on the same slot");

    // A pushed result shows up on the output the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

FILE: sv/timed_action_scheduler_top.sv
// Top level of the timed action scheduler: controller plus slot datapath.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  request | in_valid/in_ready, op, now_ms, action_code,          | in
//          | target_id, delay_ms                                  |
//  result  | out_valid/out_ready, kind, action_out, target_out,   | out
//          | slot_out, last                                       |
//
// An add checks one slot per cycle, lowest first, until a free one is found.
// In a tick each slot passes through a memory read state and a compare state on the
// single read port of the deadline memory. One request is worked on at a time; in_ready
// is high only between requests. A full output register stalls the scan when a result
// must move into it; the last result of a tick is held back until the scan ends so that
// its last flag is known. Reset frees all slots at once.
`default_nettype none

module timed_action_scheduler_top #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [31:0] now_ms,
    input  wire logic [3:0]  action_code,
    input  wire logic [2:0]  target_id,
    input  wire logic [31:0] delay_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [3:0]       action_out,
    output logic [2:0]       target_out,
    output logic [2:0]       slot_out,
    output logic             last
);

    tas_pkg::cmd_t cmd;
    tas_pkg::sts_t sts;

    tas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tas_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .now_ms      (now_ms),
        .action_code (action_code),
        .target_id   (target_id),
        .delay_ms    (delay_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .action_out  (action_out),
        .target_out  (target_out),
        .slot_out    (slot_out),
        .last        (last)
    );

endmodule

`default_nettype wire
